/* rtl/sorted_quartile_finder_macros.svh */
// Assertion macros shared by the quartile finder RTL.
`ifndef SORTED_QUARTILE_FINDER_MACROS_SVH
`define SORTED_QUARTILE_FINDER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SQF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SQF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sqf_pkg.sv */
// Shared constants and types of the quartile finder.
package sqf_pkg;

    localparam int CAPACITY  = 64;
    localparam int SAMPLE_W  = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_W     = 3 * SAMPLE_W;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast sample in order
        logic shift;  // move every value one cell toward cell 0
    } cell_ctrl_t;

endpackage

/* rtl/sqf_cell.sv */
// One cell of the sorted insertion chain: holds a single value.
module sqf_cell (
    input  logic                                aclk,
    input  sqf_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [sqf_pkg::SAMPLE_W-1:0] ins_value,
    input  logic                                occ,
    input  logic signed [sqf_pkg::SAMPLE_W-1:0] left_value,
    input  logic                                left_gt,
    input  logic signed [sqf_pkg::SAMPLE_W-1:0] right_value,
    output logic signed [sqf_pkg::SAMPLE_W-1:0] value,
    output logic                                gt
);
    import sqf_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;

    // Empty cells and cells holding a larger value give way to the new sample
    assign gt    = !occ || (value_reg > ins_value);
    assign value = value_reg;

    // Take the right neighbor on drain, the left neighbor or the sample on insert
    always_comb begin
        value_next = value_reg;
        if (ctrl.shift) begin
            value_next = right_value;
        end else if (ctrl.ins && gt) begin
            value_next = left_gt ? left_value : ins_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* rtl/sorted_quartile_finder.sv */
// Quartile finder: a chain of 64 compare-and-shift cells keeps the samples of a set
// sorted, inserting one sample per cycle, so a set loads at one beat per clock.
// A beat with tlast closes the set: the chain then drains toward cell 0 one entry
// per cycle while a counter picks out the entries at n/4, n/2 and 3*(n/4), n being
// the values held (averaged with the entry before when n/4 or n/2 is exact); no beat
// is taken until the drain ends and the result register is free. Samples beyond 64
// are dropped and the result reports status 2; an empty set reports status 1 with zero values.
`include "sorted_quartile_finder_macros.svh"

module sorted_quartile_finder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sqf_pkg::SAMPLE_W-1:0]     s_tdata,  // [31:0] sample
    input  logic [0:0]                       s_tuser,  // [0] has_sample
    input  logic                             s_tlast,  // end_of_set
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sqf_pkg::OUT_W-1:0]        m_tdata,  // [31:0] first_quartile,
                                                       // [63:32] median,
                                                       // [95:64] third_quartile
    output logic [1:0]                       m_tuser   // [1:0] status
);
    import sqf_pkg::*;

    typedef enum logic {
        LOAD,
        DRAIN
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           held_count_reg, held_count_next;
    logic                       overflow_reg, overflow_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       set_ovf_reg, set_ovf_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] q1_reg, q1_next;
    logic signed [SAMPLE_W-1:0] q2_reg, q2_next;
    logic signed [SAMPLE_W-1:0] q3_reg, q3_next;
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]           m_data_reg, m_data_next;
    logic [1:0]                 m_status_reg, m_status_next;

    logic                       s_fire;
    logic                       has_sample;
    logic                       full;
    logic                       do_ins;
    logic                       out_free;
    cell_ctrl_t                 cell_ctrl;
    logic signed [SAMPLE_W-1:0] sample;

    logic signed [SAMPLE_W-1:0] cell_value [CAPACITY];
    logic                       cell_gt    [CAPACITY];
    logic                       cell_occ   [CAPACITY];
    logic signed [SAMPLE_W-1:0] left_value [CAPACITY];
    logic                       left_gt    [CAPACITY];
    logic signed [SAMPLE_W-1:0] right_value[CAPACITY];

    logic [CNT_W-1:0]           iq1, iq2, iq3;
    logic                       avg4, avg2;
    logic signed [SAMPLE_W-1:0] drain_value;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   pair_adj;
    logic signed [SAMPLE_W-1:0] pair_mean;
    logic                       draining;
    logic                       drain_done;

    assign sample     = s_tdata[SAMPLE_W-1:0];
    assign has_sample = s_tuser[0];
    assign s_tready   = (state_reg == LOAD);
    assign s_fire     = s_tvalid && s_tready;
    assign full       = (held_count_reg == CNT_W'(CAPACITY));
    assign do_ins     = s_fire && has_sample && !full;
    assign out_free   = !m_valid_reg || m_tready;

    assign draining   = (state_reg == DRAIN) && (idx_reg < n_reg);
    assign drain_done = (state_reg == DRAIN) && (idx_reg == n_reg);

    assign cell_ctrl.ins   = do_ins;
    assign cell_ctrl.shift = draining;

    // Build the chain with its neighbor links
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < held_count_reg);

        if (i == 0) begin : g_first
            assign left_value[i] = '0;
            assign left_gt[i]    = 1'b0;
        end else begin : g_inner
            assign left_value[i] = cell_value[i-1];
            assign left_gt[i]    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value[i] = '0;
        end else begin : g_body
            assign right_value[i] = cell_value[i+1];
        end

        sqf_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .ins_value   (sample),
            .occ         (cell_occ[i]),
            .left_value  (left_value[i]),
            .left_gt     (left_gt[i]),
            .right_value (right_value[i]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    // Quartile positions of the closed set
    assign iq1  = n_reg >> 2;
    assign iq2  = n_reg >> 1;
    assign iq3  = iq1 + (iq1 << 1);
    assign avg4 = (n_reg[1:0] == 2'b00);
    assign avg2 = (n_reg[0] == 1'b0);

    // Mean of the drained entry and the one before it, truncated toward zero
    assign drain_value = cell_value[0];
    assign pair_sum    = {drain_value[SAMPLE_W-1], drain_value} + {prev_reg[SAMPLE_W-1], prev_reg};
    assign pair_adj    = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W] & pair_sum[0]};
    assign pair_mean   = pair_adj[SAMPLE_W:1];

    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        overflow_next   = overflow_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        set_ovf_next    = set_ovf_reg;
        prev_next       = prev_reg;
        q1_next         = q1_reg;
        q2_next         = q2_reg;
        q3_next         = q3_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            LOAD: begin
                if (s_fire) begin
                    if (do_ins) begin
                        held_count_next = held_count_reg + CNT_W'(1);
                    end
                    if (has_sample && full) begin
                        overflow_next = 1'b1;
                    end
                    // Close the set and start draining
                    if (s_tlast) begin
                        n_next          = do_ins ? held_count_reg + CNT_W'(1) : held_count_reg;
                        set_ovf_next    = overflow_reg || (has_sample && full);
                        held_count_next = '0;
                        overflow_next   = 1'b0;
                        idx_next        = '0;
                        q1_next         = '0;
                        q2_next         = '0;
                        q3_next         = '0;
                        state_next      = DRAIN;
                    end
                end
            end
            DRAIN: begin
                if (draining) begin
                    // Capture entries at the quartile positions
                    if (idx_reg == iq1) begin
                        q1_next = (avg4 && idx_reg != '0) ? pair_mean : drain_value;
                    end
                    if (idx_reg == iq2) begin
                        q2_next = (avg2 && idx_reg != '0) ? pair_mean : drain_value;
                    end
                    if (idx_reg == iq3) begin
                        q3_next = (avg4 && idx_reg != '0) ? pair_mean : drain_value;
                    end
                    prev_next = drain_value;
                    idx_next  = idx_reg + CNT_W'(1);
                end else if (drain_done && out_free) begin
                    // Hand the result to the output register
                    m_valid_next = 1'b1;
                    m_data_next  = {q3_reg, q2_reg, q1_reg};
                    if (n_reg == '0) begin
                        m_status_next = ST_EMPTY;
                    end else if (set_ovf_reg) begin
                        m_status_next = ST_OVERFLOW;
                    end else begin
                        m_status_next = ST_OK;
                    end
                    state_next = LOAD;
                end
            end
            default: begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= LOAD;
            held_count_reg <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
            set_ovf_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            overflow_reg   <= overflow_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            set_ovf_reg    <= set_ovf_next;
            m_valid_reg    <= m_valid_next;
        end
        prev_reg     <= prev_next;
        q1_reg       <= q1_next;
        q2_reg       <= q2_next;
        q3_reg       <= q3_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Checks on count, drain and result
    `SQF_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, held_count_reg <= CNT_W'(CAPACITY), "held count above capacity")
    `SQF_ASSERT_NEXT(a_close_stalls, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "input not stalled after closing beat")
    `SQF_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser == ST_EMPTY, m_tdata == '0, "empty set result not zero")
    `SQF_ASSERT_IMP(a_drain_bound, aclk, aresetn, state_reg == DRAIN, idx_reg <= n_reg && n_reg <= CNT_W'(CAPACITY), "drain index past set size")

endmodule
